FILE: rtl/jaq_pkg.sv
`default_nettype none
package jaq_pkg;

	localparam int MAX_BUTTONS_DEF = 16;

	localparam int AXIS_W     = 16;
	localparam int BUTTON_W   = 16;
	localparam int TIME_W     = 32;
	localparam int DELAY_W    = 16;
	localparam int COUNT_W    = 5;
	localparam int KIND_W     = 2;
	localparam int DIR_W      = 4;
	localparam int IDX_W      = 4;
	localparam int CODE_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [AXIS_W-1:0] AXIS_HIGH = 16'sd16384;
	localparam logic signed [AXIS_W-1:0] AXIS_LOW  = -16'sd16384;

	localparam logic [DIR_W-1:0] DIR_CENTER = 4'd4;

	localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
	localparam logic [KIND_W-1:0] EV_DIR  = 2'd1;
	localparam logic [KIND_W-1:0] EV_BTN  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_DELAY    = 3'd4;

	localparam logic [COUNT_W-1:0] RST_BUTTON_COUNT    = 5'd16;
	localparam logic [DELAY_W-1:0] RST_FIRST_DELAY     = 16'd100;
	localparam logic [DELAY_W-1:0] RST_REPEAT_INTERVAL = 16'd60;
	localparam logic [DELAY_W-1:0] RST_BUTTON_DELAY    = 16'd300;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x_axis;
		logic signed [AXIS_W-1:0] y_axis;
		logic [BUTTON_W-1:0]      buttons;
		logic [TIME_W-1:0]        now_ms;
	} poll_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [DIR_W-1:0]  direction;
		logic [IDX_W-1:0]  button_index;
		logic [CODE_W-1:0] button_code;
	} result_t;

	typedef struct packed {
		logic             fire;
		logic [DIR_W-1:0] direction;
	} dir_evt_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  index;
		logic [CODE_W-1:0] code;
	} btn_evt_t;

	function automatic logic [1:0] zone_of(input logic signed [AXIS_W-1:0] s);
		logic [1:0] z;
		if (s > AXIS_HIGH) begin
			z = 2'd2;
		end else if (s > AXIS_LOW) begin
			z = 2'd1;
		end else begin
			z = 2'd0;
		end
		return z;
	endfunction

	// elapsed time read as signed, must be positive and past the delay
	function automatic logic expired(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] start, input logic [DELAY_W-1:0] delay);
		logic [TIME_W-1:0] diff;
		diff = now - start;
		return !diff[TIME_W-1] && (diff > {{(TIME_W-DELAY_W){1'b0}}, delay});
	endfunction

	function automatic logic [CODE_W-1:0] code_of(input logic [IDX_W-1:0] i);
		logic [CODE_W-1:0] c;
		case (i)
			4'd0:    c = 7'h66;
			4'd1:    c = 7'h20;
			4'd2:    c = 7'h2B;
			4'd3:    c = 7'h2D;
			4'd4:    c = 7'h2F;
			4'd5:    c = 7'h2A;
			4'd6:    c = 7'h2F;
			4'd7:    c = 7'h2A;
			4'd8:    c = 7'h76;
			4'd9:    c = 7'h4F;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/jaq_if.sv
`default_nettype none
interface jaq_poll_if;
	import jaq_pkg::*;
	logic  valid;
	logic  ready;
	poll_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface jaq_result_if;
	import jaq_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/jaq_dir.sv
`default_nettype none
module jaq_dir (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           commit,
	input  wire logic signed [jaq_pkg::AXIS_W-1:0] x_axis,
	input  wire logic signed [jaq_pkg::AXIS_W-1:0] y_axis,
	input  wire logic [jaq_pkg::TIME_W-1:0]     now_ms,
	input  wire logic [jaq_pkg::DELAY_W-1:0]    first_delay,
	input  wire logic [jaq_pkg::DELAY_W-1:0]    repeat_interval,
	output jaq_pkg::dir_evt_t                   evt
);
	import jaq_pkg::*;

	logic [DIR_W-1:0]   last_dir_q;
	logic [TIME_W-1:0]  dir_start_q;
	logic               repeating_q;

	logic [1:0]         zx;
	logic [1:0]         zy;
	logic [DIR_W-1:0]   dir;
	logic               changed;
	logic               timed_out;
	logic [DELAY_W-1:0] delay;

	always_comb begin
		zx        = zone_of(x_axis);
		zy        = zone_of(y_axis);
		dir       = {2'b00, zx} + {2'b00, zy} + {1'b0, zy, 1'b0};
		changed   = dir != last_dir_q;
		delay     = repeating_q ? repeat_interval : first_delay;
		timed_out = expired(now_ms, dir_start_q, delay);
		evt.direction = dir;
		evt.fire      = (changed || timed_out) && (dir != DIR_CENTER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q  <= DIR_CENTER;
			dir_start_q <= '0;
			repeating_q <= 1'b0;
		end else if (commit) begin
			if (changed) begin
				last_dir_q  <= dir;
				dir_start_q <= now_ms;
				repeating_q <= 1'b0;
			end else if (timed_out) begin
				dir_start_q <= now_ms;
				repeating_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/jaq_btn.sv
`default_nettype none
module jaq_btn #(
	parameter int MAX_BUTTONS = jaq_pkg::MAX_BUTTONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          commit,
	input  wire logic [jaq_pkg::BUTTON_W-1:0]  buttons,
	input  wire logic [jaq_pkg::TIME_W-1:0]    now_ms,
	input  wire logic [jaq_pkg::COUNT_W-1:0]   button_count,
	input  wire logic [jaq_pkg::DELAY_W-1:0]   button_delay,
	output jaq_pkg::btn_evt_t                  evt
);
	import jaq_pkg::*;

	logic                  prev_q [MAX_BUTTONS];
	logic [TIME_W-1:0]     start_q [MAX_BUTTONS];

	logic [MAX_BUTTONS-1:0] level;
	logic [MAX_BUTTONS-1:0] fire;
	logic [MAX_BUTTONS-1:0] upd;

	// all lanes in parallel, lowest hitting lane wins and masks those above
	always_comb begin
		logic              below;
		logic [CODE_W-1:0] code;
		below = 1'b0;
		evt   = '0;
		for (int i = 0; i < MAX_BUTTONS; i++) begin
			level[i] = (i < BUTTON_W) ? buttons[IDX_W'(i)] : 1'b0;
			code     = (i < BUTTON_W) ? code_of(IDX_W'(i)) : '0;
			fire[i]  = level[i] && ((level[i] != prev_q[i]) ||
				expired(now_ms, start_q[i], button_delay));
			upd[i]   = (COUNT_W'(i) < button_count) && !below;
			if (upd[i] && fire[i] && (code != '0)) begin
				below     = 1'b1;
				evt.hit   = 1'b1;
				evt.index = IDX_W'(i);
				evt.code  = code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				prev_q[i]  <= 1'b0;
				start_q[i] <= '0;
			end
		end else if (commit) begin
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				if (upd[i]) begin
					prev_q[i] <= level[i];
					if (fire[i]) begin
						start_q[i] <= now_ms;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/joystick_autorepeat_qualifier_unit.sv
// channel   dir  beat fields                                   handshake
// poll      in   x_axis, y_axis, buttons, now_ms               valid / ready
// result    out  event_kind, direction, button_index, code     valid / ready
// cfg       in   cfg_index, cfg_data                           cfg_we, no stall
//
// a poll beat is held in the input register, then is qualified and
// lands in the result register; one beat per cycle unless result stalls
// qualifier state updates as a beat moves on
// result stall holds the result register, the input register still takes one beat
// arst_n restores register defaults, center direction and released buttons
`default_nettype none
module joystick_autorepeat_qualifier_unit #(
	parameter int MAX_BUTTONS = jaq_pkg::MAX_BUTTONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [jaq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [jaq_pkg::CFG_DATA_W-1:0]  cfg_data,
	jaq_poll_if.sink                             poll,
	jaq_result_if.source                         result
);
	import jaq_pkg::*;

	logic               enabled_q;
	logic [COUNT_W-1:0] button_count_q;
	logic [DELAY_W-1:0] first_delay_q;
	logic [DELAY_W-1:0] repeat_interval_q;
	logic [DELAY_W-1:0] button_delay_q;

	logic    valid_s1;
	poll_t   poll_s1;
	logic    res_valid_q;
	result_t res_q;

	logic     advance;
	logic     commit_dir;
	logic     commit_btn;
	dir_evt_t dir_evt;
	btn_evt_t btn_evt;
	result_t  res_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q         <= 1'b1;
			button_count_q    <= RST_BUTTON_COUNT;
			first_delay_q     <= RST_FIRST_DELAY;
			repeat_interval_q <= RST_REPEAT_INTERVAL;
			button_delay_q    <= RST_BUTTON_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLED:         enabled_q         <= cfg_data[0];
				REG_BUTTON_COUNT:    button_count_q    <= cfg_data[COUNT_W-1:0];
				REG_FIRST_DELAY:     first_delay_q     <= cfg_data[DELAY_W-1:0];
				REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data[DELAY_W-1:0];
				REG_BUTTON_DELAY:    button_delay_q    <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;
	assign commit_dir = advance && enabled_q;
	assign commit_btn = commit_dir && !dir_evt.fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1 <= poll.data;
		end
	end

	jaq_dir u_dir (
		.clk             (clk),
		.arst_n          (arst_n),
		.commit          (commit_dir),
		.x_axis          (poll_s1.x_axis),
		.y_axis          (poll_s1.y_axis),
		.now_ms          (poll_s1.now_ms),
		.first_delay     (first_delay_q),
		.repeat_interval (repeat_interval_q),
		.evt             (dir_evt)
	);

	jaq_btn #(
		.MAX_BUTTONS (MAX_BUTTONS)
	) u_btn (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit_btn),
		.buttons      (poll_s1.buttons),
		.now_ms       (poll_s1.now_ms),
		.button_count (button_count_q),
		.button_delay (button_delay_q),
		.evt          (btn_evt)
	);

	always_comb begin
		res_next = '0;
		if (enabled_q) begin
			if (dir_evt.fire) begin
				res_next.event_kind = EV_DIR;
				res_next.direction  = dir_evt.direction;
			end else if (btn_evt.hit) begin
				res_next.event_kind   = EV_BTN;
				res_next.button_index = btn_evt.index;
				res_next.button_code  = btn_evt.code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
`default_nettype wire

FILE: rtl/jaq_chk.sv
`default_nettype none
module jaq_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire jaq_pkg::result_t res_data
);
	import jaq_pkg::*;

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed under stall");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.event_kind == EV_NONE) ||
			(res_data.event_kind == EV_DIR) || (res_data.event_kind == EV_BTN))
		else $error("illegal event kind");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_kind == EV_NONE) |->
			(res_data.direction == '0) && (res_data.button_index == '0) &&
			(res_data.button_code == '0))
		else $error("empty beat carries data");

	a_dir_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_kind == EV_DIR) |->
			(res_data.direction != DIR_CENTER) && (res_data.direction < 4'd9) &&
			(res_data.button_index == '0) && (res_data.button_code == '0))
		else $error("bad direction beat");

	a_btn_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.event_kind == EV_BTN) |->
			(res_data.button_code != '0) && (res_data.direction == '0) &&
			(res_data.button_index < 4'd10))
		else $error("bad button beat");

endmodule

bind joystick_autorepeat_qualifier_unit jaq_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
`default_nettype wire
